// ===== rtl/core/ugnq_pkg.sv =====
// ----------------------------------------------------------------------------
// ugnq_pkg
// Shared constants, command and status codes for the neighbour query grid.
// ----------------------------------------------------------------------------
package ugnq_pkg;

  localparam int unsigned GRID_DIM_DEF = 16;
  localparam int unsigned CELL_CAP_DEF = 2;
  localparam int unsigned ID_WIDTH_DEF = 16;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam int unsigned POS_W  = 32;
  localparam int unsigned CS_W   = 31;
  localparam int unsigned PID_W  = 16;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CNT_W  = 2;

  localparam logic [CS_W-1:0] CELL_SIZE_RST = 31'd65536;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_OFF_GRID = 2'd2
  } status_e;

endpackage

// ===== rtl/core/ugnq_ram.sv =====
// ----------------------------------------------------------------------------
// ugnq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ugnq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ugnq_queue.sv =====
// ----------------------------------------------------------------------------
// ugnq_queue
// Small register FIFO between the front and the back.
// ----------------------------------------------------------------------------
module ugnq_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned NW   = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [NW-1:0]    fill_q;
  logic             push, pop;

  assign wr_ready_o = (fill_q != NW'(DEPTH));
  assign rd_valid_o = (fill_q != '0);
  assign rd_data_o  = slot_q[rptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (push && !pop) begin
        fill_q <= fill_q + NW'(1);
      end else if (pop && !push) begin
        fill_q <= fill_q - NW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/ugnq_front.sv =====
// ----------------------------------------------------------------------------
// ugnq_front
// Accept commands, divide the three coordinates of an insert or query by the
// cell size and queue.
module ugnq_front import ugnq_pkg::*; #(
  parameter int unsigned GRID_DIM = GRID_DIM_DEF,
  parameter int unsigned ID_WIDTH = ID_WIDTH_DEF,
  localparam int unsigned CW      = $clog2(GRID_DIM + 2) + 1,
  localparam int unsigned EW      = CMD_W + ID_WIDTH + 3 * CW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CMD_W-1:0] command_i,
  input  logic [PID_W-1:0] particle_id_i,
  input  logic [POS_W-1:0] pos_x_i,
  input  logic [POS_W-1:0] pos_y_i,
  input  logic [POS_W-1:0] pos_z_i,
  input  logic [CS_W-1:0]  cell_size_i,
  input  logic             init_done_i,
  output logic             q_valid_o,
  input  logic             q_ready_i,
  output logic [EW-1:0]    q_data_o
);

  localparam int unsigned HALF   = GRID_DIM / 2;
  localparam int unsigned FAR_LO = HALF + 2;
  localparam int unsigned FAR_HI = GRID_DIM - HALF + 1;
  localparam int unsigned SW     = $clog2(POS_W);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_e;

  fstate_e              state_q;
  logic [SW-1:0]        step_q;
  logic                 accept, load;
  logic [CMD_W-1:0]     cmd_q;
  logic [ID_WIDTH-1:0]  id_q;
  logic [ID_WIDTH+15:0] id_ext;
  logic [CS_W-1:0]      div_q;
  logic [POS_W-1:0]     pos_in [3];
  logic                 neg_q  [3];
  logic [CS_W-1:0]      rem_q  [3];
  logic [POS_W-1:0]     dq_q   [3];
  logic [CS_W-1:0]      rem_d  [3];
  logic [POS_W-1:0]     dq_d   [3];
  logic signed [CW-1:0] coord  [3];

  assign pos_in[0] = pos_x_i;
  assign pos_in[1] = pos_y_i;
  assign pos_in[2] = pos_z_i;
  assign id_ext    = {{ID_WIDTH{1'b0}}, particle_id_i};

  assign in_ready_o = (state_q == F_IDLE) && init_done_i;
  assign accept     = in_valid_i && in_ready_o;
  assign load       = accept && ((command_i == CMD_INSERT) || (command_i == CMD_QUERY));

  // One restoring division step per lane and cycle.
  always_comb begin
    logic [POS_W-1:0] rsh;
    logic [POS_W-1:0] dv;
    logic [POS_W-1:0] diff;
    for (int a = 0; a < 3; a++) begin
      rsh      = {rem_q[a], dq_q[a][POS_W-1]};
      dv       = {1'b0, div_q};
      diff     = rsh - dv;
      rem_d[a] = (rsh >= dv) ? diff[CS_W-1:0] : rsh[CS_W-1:0];
      dq_d[a]  = {dq_q[a][POS_W-2:0], (rsh >= dv)};
    end
  end

  // Centre the quotient; far cells are clamped just beyond any neighbour reach.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (neg_q[a]) begin
        coord[a] = (dq_q[a] >= POS_W'(FAR_LO)) ? -$signed(CW'(2))
                 : $signed(CW'(HALF) - dq_q[a][CW-1:0]);
      end else begin
        coord[a] = (dq_q[a] >= POS_W'(FAR_HI)) ? $signed(CW'(GRID_DIM + 1))
                 : $signed(CW'(HALF) + dq_q[a][CW-1:0]);
      end
    end
  end

  assign q_valid_o = (state_q == F_PUSH);
  assign q_data_o  = {cmd_q, id_q, coord[2], coord[1], coord[0]};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      id_q  <= id_ext[ID_WIDTH-1:0];
      div_q <= (cell_size_i == '0) ? CS_W'(1) : cell_size_i;
    end
    for (int a = 0; a < 3; a++) begin
      if (load) begin
        neg_q[a] <= pos_in[a][POS_W-1];
        rem_q[a] <= '0;
        dq_q[a]  <= pos_in[a][POS_W-1] ? (~pos_in[a] + POS_W'(1)) : pos_in[a];
      end else if (state_q == F_DIV) begin
        rem_q[a] <= rem_d[a];
        dq_q[a]  <= dq_d[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (accept) begin
            step_q <= '0;
            case (cmd_e'(command_i))
              CMD_CLEAR:              state_q <= F_PUSH;
              CMD_INSERT, CMD_QUERY:  state_q <= F_DIV;
              default:                state_q <= F_IDLE;
            endcase
          end
        end
        F_DIV: begin
          step_q <= step_q + SW'(1);
          if (step_q == SW'(POS_W - 1)) begin
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (q_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/ugnq_back.sv =====
// ----------------------------------------------------------------------------
// ugnq_back
// Execute clear, insert and query against the cell count and member memories.
// ----------------------------------------------------------------------------
module ugnq_back import ugnq_pkg::*; #(
  parameter int unsigned GRID_DIM = GRID_DIM_DEF,
  parameter int unsigned CELL_CAP = CELL_CAP_DEF,
  parameter int unsigned ID_WIDTH = ID_WIDTH_DEF,
  localparam int unsigned CW      = $clog2(GRID_DIM + 2) + 1,
  localparam int unsigned EW      = CMD_W + ID_WIDTH + 3 * CW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  logic [EW-1:0]     q_data_i,
  output logic              init_done_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PID_W-1:0]  neighbour_id_o,
  output logic              found_o,
  output logic [STAT_W-1:0] status_o,
  output logic              last_o
);

  localparam int unsigned NCELLS = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int unsigned CIW    = $clog2(NCELLS);
  localparam int unsigned MDEPTH = NCELLS * CELL_CAP;
  localparam int unsigned MAW    = $clog2(MDEPTH);

  typedef enum logic [3:0] {
    B_INIT, B_IDLE, B_CLEAR, B_INS_CHK, B_INS_RD, B_RESP,
    B_Q_CELL, B_Q_CNT, B_Q_RD, B_Q_MEM, B_Q_FINAL
  } bstate_e;

  bstate_e              state_q;
  logic [CIW-1:0]       sweep_q, cell_q;
  cmd_e                 cmd_in;
  logic [ID_WIDTH-1:0]  id_q;
  logic signed [CW-1:0] c_q  [3];
  logic [1:0]           o_q  [3];
  logic [1:0]           o_nx [3];
  logic                 o_done;
  logic signed [CW:0]   nc   [3];
  logic                 n_on, c_on;
  logic [CIW-1:0]       cell_c;
  logic [CNT_W-1:0]     n_q, cnt_rd, cnt_lim;
  logic                 slot_q;
  logic                 hold_valid_q;
  logic [ID_WIDTH-1:0]  hold_id_q, mem_rd;
  status_e              resp_q, qstat;
  logic                 can_push, more_slots, out_load;
  logic                 out_valid_q, out_found_q, out_last_q;
  logic [ID_WIDTH-1:0]  out_id_q;
  status_e              out_status_q;
  logic [ID_WIDTH+15:0] out_ext;

  logic                 cnt_we;
  logic [CIW-1:0]       cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]     cnt_wdata;
  logic                 mem_we;
  logic [MAW-1:0]       mem_waddr, mem_raddr;

  assign cmd_in = cmd_e'(q_data_i[3*CW+ID_WIDTH +: CMD_W]);

  // Neighbour coordinates from centre and offset.
  always_comb begin
    n_on = 1'b1;
    c_on = 1'b1;
    for (int a = 0; a < 3; a++) begin
      nc[a] = $signed({c_q[a][CW-1], c_q[a]}) + $signed({{(CW-1){1'b0}}, o_q[a]})
            - $signed((CW+1)'(1));
      n_on  = n_on && (nc[a] >= 0) && (nc[a] < $signed((CW+1)'(GRID_DIM)));
      c_on  = c_on && (c_q[a] >= 0) && (c_q[a] < $signed(CW'(GRID_DIM)));
    end
    cell_c = CIW'((CIW'(nc[2][CW-1:0]) * CIW'(GRID_DIM) + CIW'(nc[1][CW-1:0]))
                  * CIW'(GRID_DIM) + CIW'(nc[0][CW-1:0]));
  end

  // Walk offsets with x fastest, then y, then z.
  always_comb begin
    o_nx[0] = o_q[0];
    o_nx[1] = o_q[1];
    o_nx[2] = o_q[2];
    o_done  = (o_q[0] == 2'd2) && (o_q[1] == 2'd2) && (o_q[2] == 2'd2);
    if (o_q[0] != 2'd2) begin
      o_nx[0] = o_q[0] + 2'd1;
    end else begin
      o_nx[0] = 2'd0;
      if (o_q[1] != 2'd2) begin
        o_nx[1] = o_q[1] + 2'd1;
      end else begin
        o_nx[1] = 2'd0;
        o_nx[2] = o_q[2] + 2'd1;
      end
    end
  end

  assign qstat      = c_on ? STAT_OK : STAT_OFF_GRID;
  assign can_push   = !out_valid_q || out_ready_i;
  assign cnt_lim    = (cnt_rd > CNT_W'(CELL_CAP)) ? CNT_W'(CELL_CAP) : cnt_rd;
  assign more_slots = ({1'b0, slot_q} + CNT_W'(1)) < n_q;
  assign out_load   = can_push && ((state_q == B_RESP) || (state_q == B_Q_FINAL) ||
                      ((state_q == B_Q_MEM) && (mem_rd != id_q) && hold_valid_q));

  assign cnt_we    = (state_q == B_INIT) || (state_q == B_CLEAR) || mem_we;
  assign cnt_waddr = mem_we ? cell_q : sweep_q;
  assign cnt_wdata = mem_we ? cnt_rd + CNT_W'(1) : '0;
  assign cnt_raddr = ((state_q == B_Q_CELL) || (state_q == B_INS_CHK)) ? cell_c : cell_q;
  assign mem_we    = (state_q == B_INS_RD) && (cnt_rd < CNT_W'(CELL_CAP));
  assign mem_waddr = MAW'(MAW'(cell_q) * MAW'(CELL_CAP) + MAW'(cnt_rd));
  assign mem_raddr = MAW'(MAW'(cell_q) * MAW'(CELL_CAP) + MAW'(slot_q));

  ugnq_ram #(.WIDTH(CNT_W), .DEPTH(NCELLS)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rd)
  );

  ugnq_ram #(.WIDTH(ID_WIDTH), .DEPTH(MDEPTH)) u_member_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (id_q),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rd)
  );

  assign q_ready_o      = (state_q == B_IDLE);
  assign init_done_o    = (state_q != B_INIT);
  assign out_ext        = {16'd0, out_id_q};
  assign out_valid_o    = out_valid_q;
  assign neighbour_id_o = out_ext[PID_W-1:0];
  assign found_o        = out_found_q;
  assign status_o       = out_status_q;
  assign last_o         = out_last_q;

  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && q_valid_i) begin
      id_q <= q_data_i[3*CW +: ID_WIDTH];
      for (int a = 0; a < 3; a++) begin
        c_q[a] <= $signed(q_data_i[a*CW +: CW]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_INIT;
      sweep_q      <= '0;
      cell_q       <= '0;
      n_q          <= '0;
      slot_q       <= 1'b0;
      o_q[0]       <= '0;
      o_q[1]       <= '0;
      o_q[2]       <= '0;
      hold_valid_q <= 1'b0;
      hold_id_q    <= '0;
      resp_q       <= STAT_OK;
      out_valid_q  <= 1'b0;
      out_id_q     <= '0;
      out_found_q  <= 1'b0;
      out_status_q <= STAT_OK;
      out_last_q   <= 1'b0;
    end else begin
      if (out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_INIT, B_CLEAR: begin
          sweep_q <= sweep_q + CIW'(1);
          if (sweep_q == CIW'(NCELLS - 1)) begin
            resp_q  <= STAT_OK;
            state_q <= (state_q == B_INIT) ? B_IDLE : B_RESP;
          end
        end
        B_IDLE: begin
          if (q_valid_i) begin
            case (cmd_in)
              CMD_CLEAR: begin
                sweep_q <= '0;
                state_q <= B_CLEAR;
              end
              CMD_INSERT: begin
                o_q[0]  <= 2'd1;
                o_q[1]  <= 2'd1;
                o_q[2]  <= 2'd1;
                state_q <= B_INS_CHK;
              end
              CMD_QUERY: begin
                o_q[0]       <= 2'd0;
                o_q[1]       <= 2'd0;
                o_q[2]       <= 2'd0;
                hold_valid_q <= 1'b0;
                state_q      <= B_Q_CELL;
              end
              default: state_q <= B_IDLE;
            endcase
          end
        end
        B_INS_CHK: begin
          cell_q <= cell_c;
          if (!c_on) begin
            resp_q  <= STAT_OFF_GRID;
            state_q <= B_RESP;
          end else begin
            state_q <= B_INS_RD;
          end
        end
        B_INS_RD: begin
          resp_q  <= (cnt_rd < CNT_W'(CELL_CAP)) ? STAT_OK : STAT_FULL;
          state_q <= B_RESP;
        end
        B_RESP: begin
          if (can_push) begin
            out_valid_q  <= 1'b1;
            out_id_q     <= '0;
            out_found_q  <= 1'b0;
            out_status_q <= resp_q;
            out_last_q   <= 1'b1;
            state_q      <= B_IDLE;
          end
        end
        B_Q_CELL: begin
          cell_q <= cell_c;
          if (n_on) begin
            state_q <= B_Q_CNT;
          end else begin
            o_q     <= o_nx;
            state_q <= o_done ? B_Q_FINAL : B_Q_CELL;
          end
        end
        B_Q_CNT: begin
          n_q    <= cnt_lim;
          slot_q <= 1'b0;
          if (cnt_lim == '0) begin
            o_q     <= o_nx;
            state_q <= o_done ? B_Q_FINAL : B_Q_CELL;
          end else begin
            state_q <= B_Q_RD;
          end
        end
        B_Q_RD: begin
          state_q <= B_Q_MEM;
        end
        B_Q_MEM: begin
          // Hold the newest match back so the final one can carry last.
          if (!(mem_rd != id_q && hold_valid_q && !can_push)) begin
            if (mem_rd != id_q) begin
              if (hold_valid_q) begin
                out_valid_q  <= 1'b1;
                out_id_q     <= hold_id_q;
                out_found_q  <= 1'b1;
                out_status_q <= qstat;
                out_last_q   <= 1'b0;
              end
              hold_valid_q <= 1'b1;
              hold_id_q    <= mem_rd;
            end
            if (more_slots) begin
              slot_q  <= 1'b1;
              state_q <= B_Q_RD;
            end else begin
              o_q     <= o_nx;
              state_q <= o_done ? B_Q_FINAL : B_Q_CELL;
            end
          end
        end
        B_Q_FINAL: begin
          if (can_push) begin
            out_valid_q  <= 1'b1;
            out_id_q     <= hold_valid_q ? hold_id_q : '0;
            out_found_q  <= hold_valid_q;
            out_status_q <= qstat;
            out_last_q   <= 1'b1;
            state_q      <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/uniform_grid_neighbour_query.sv =====
// ----------------------------------------------------------------------------
// uniform_grid_neighbour_query
// Broad-phase collision grid: clear, insert and 27-cell neighbour query.
// ----------------------------------------------------------------------------
//
//  channel   handshake                     payload
//  -------   ---------------------------   --------------------------------------
//  input     in_valid_i / in_ready_o       command, particle_id, pos_x/y/z
//  output    out_valid_o / out_ready_i     neighbour_id, found, status, last
//  config    cell_size_we_i                cell_size_i
//
// Front: all three axes are divided at once in a radix-2 divider; a clear
// skips the divide. The back then checks the cell and reads its count for an
// insert, sweeps all GRID_DIM^3 count entries for a clear (one count entry
// swept per cycle), and for a query steps past one off-grid neighbour per
// cycle and reads the count and then each member of every on-grid one,
// bounded by the single read port of each memory.
// Reset: a clearing pass over all GRID_DIM^3 count entries zeroes the count
// memory; no input transaction is taken until it finishes.
// Stalls: a two-entry queue separates front and back, and the output
// register lets the back run ahead by one result while the sink stalls.
//
module uniform_grid_neighbour_query import ugnq_pkg::*; #(
  parameter int unsigned GRID_DIM = GRID_DIM_DEF,
  parameter int unsigned CELL_CAP = CELL_CAP_DEF,
  parameter int unsigned ID_WIDTH = ID_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cell_size_we_i,
  input  logic [CS_W-1:0]   cell_size_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [PID_W-1:0]  particle_id_i,
  input  logic [POS_W-1:0]  pos_x_i,
  input  logic [POS_W-1:0]  pos_y_i,
  input  logic [POS_W-1:0]  pos_z_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PID_W-1:0]  neighbour_id_o,
  output logic              found_o,
  output logic [STAT_W-1:0] status_o,
  output logic              last_o
);

  localparam int unsigned CW = $clog2(GRID_DIM + 2) + 1;
  localparam int unsigned EW = CMD_W + ID_WIDTH + 3 * CW;

  logic [CS_W-1:0] cell_size_q;
  logic            init_done;
  logic            fq_valid, fq_ready, bq_valid, bq_ready;
  logic [EW-1:0]   fq_data, bq_data;

  // Hold the cell size; the user must write it only while the block is idle, the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= CELL_SIZE_RST;
    end else if (cell_size_we_i) begin
      cell_size_q <= cell_size_i;
    end
  end

  // Front: accept the transaction and turn positions into cell coordinates.
  ugnq_front #(.GRID_DIM(GRID_DIM), .ID_WIDTH(ID_WIDTH)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .particle_id_i (particle_id_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .cell_size_i   (cell_size_q),
    .init_done_i   (init_done),
    .q_valid_o     (fq_valid),
    .q_ready_i     (fq_ready),
    .q_data_o      (fq_data)
  );

  // Queue decoupling the divider from the grid walk.
  ugnq_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_data_i  (fq_data),
    .rd_valid_o (bq_valid),
    .rd_ready_i (bq_ready),
    .rd_data_o  (bq_data)
  );

  // Back: run the command against the grid memories and emit results.
  ugnq_back #(
    .GRID_DIM (GRID_DIM),
    .CELL_CAP (CELL_CAP),
    .ID_WIDTH (ID_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (bq_valid),
    .q_ready_o      (bq_ready),
    .q_data_i       (bq_data),
    .init_done_o    (init_done),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .neighbour_id_o (neighbour_id_o),
    .found_o        (found_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

endmodule
